>>> hdl/sqia_pkg.sv
package sqia_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] target_byte;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   head_out;
    logic [FILL_W-1:0]   fill_count;
  } rsp_item_t;

  typedef enum logic {
    SLOT_FREE,
    SLOT_HELD
  } slot_state_t;

  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

>>> hdl/sqia_ctrl.sv
module sqia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sqia_pkg::dp_cmd_t   cmd
);

  sqia_pkg::slot_state_t state;
  sqia_pkg::slot_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqia_pkg::SLOT_FREE;
    end else begin
      state <= state_next;
    end
  end

  // A new item may enter whenever the result slot is free or is being emptied.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      sqia_pkg::SLOT_FREE: begin
        req_ready = 1'b1;
        cmd.exec  = req_valid;
        if (req_valid) begin
          state_next = sqia_pkg::SLOT_HELD;
        end
      end
      sqia_pkg::SLOT_HELD: begin
        rsp_valid = 1'b1;
        req_ready = rsp_ready;
        cmd.exec  = rsp_ready && req_valid;
        if (rsp_ready && !req_valid) begin
          state_next = sqia_pkg::SLOT_FREE;
        end
      end
      default: begin
        state_next = sqia_pkg::SLOT_FREE;
      end
    endcase
  end

  a_exec_fills_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> state == sqia_pkg::SLOT_HELD)
    else $error("slot not held after an item was executed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == sqia_pkg::SLOT_HELD && !rsp_ready) |-> !cmd.exec)
    else $error("item executed while result still waiting");

  a_drain_frees: assert property (@(posedge clk) disable iff (rst)
    (state == sqia_pkg::SLOT_HELD && rsp_ready && !req_valid)
      |=> state == sqia_pkg::SLOT_FREE)
    else $error("slot not freed after result was taken");

endmodule

>>> hdl/sqia_dp.sv
module sqia_dp #(
  parameter int DEPTH = sqia_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  sqia_pkg::dp_cmd_t   cmd,
  input  sqia_pkg::req_item_t req,
  output sqia_pkg::rsp_item_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = sqia_pkg::BYTE_W;

  logic [DEPTH-1:0][BW-1:0] entries;
  logic [DEPTH-1:0][BW-1:0] entries_next;
  logic [DEPTH-1:0][BW-1:0] entries_up;
  logic [DEPTH-1:0][BW-1:0] entries_dn;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] after;
  logic [DEPTH-1:0] first_dn;
  logic [DEPTH-1:0] after_dn;
  logic             full;
  logic             empty;
  logic             found;

  sqia_pkg::rsp_item_t rsp_next;
  logic [CW+sqia_pkg::FILL_W-1:0] fill_ext;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Every live cell compares against the target in parallel; the lowest
  // matching cell is isolated with a two's complement trick.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CW'(i) < count) && (entries[i] == req.target_byte);
    end
  end

  assign first    = match & (~match + DEPTH'(1));
  assign after    = ~(first - DEPTH'(1)) & ~first;
  assign found    = |match;
  assign first_dn = {first[DEPTH-2:0], 1'b0};
  assign after_dn = {after[DEPTH-2:0], 1'b0};

  assign entries_up = {{BW{1'b0}}, entries[DEPTH-1:1]};
  assign entries_dn = {entries[DEPTH-2:0], {BW{1'b0}}};

  always_comb begin
    entries_next = entries;
    count_next   = count;
    rsp_next     = '0;
    case (req.operation)
      sqia_pkg::OP_ENQUEUE: begin
        if (full) begin
          rsp_next.status = sqia_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (count == CW'(i)) begin
              entries_next[i] = req.data_byte;
            end
          end
          count_next = count + CW'(1);
        end
      end
      sqia_pkg::OP_DEQUEUE: begin
        if (empty) begin
          rsp_next.status = sqia_pkg::ST_EMPTY;
        end else begin
          rsp_next.head_out = entries[0];
          entries_next      = entries_up;
          count_next        = count - CW'(1);
        end
      end
      sqia_pkg::OP_INSERT: begin
        if (full) begin
          rsp_next.status = sqia_pkg::ST_FULL;
        end else if (!found) begin
          rsp_next.status = sqia_pkg::ST_NOTFOUND;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (first_dn[i]) begin
              entries_next[i] = req.data_byte;
            end else if (after_dn[i]) begin
              entries_next[i] = entries_dn[i];
            end
          end
          count_next = count + CW'(1);
        end
      end
      sqia_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    fill_ext            = {{sqia_pkg::FILL_W{1'b0}}, count_next};
    rsp_next.fill_count = fill_ext[sqia_pkg::FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entries <= entries_next;
      rsp     <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.operation == sqia_pkg::OP_CLEAR) |=> count == '0)
    else $error("queue not empty after clear");

  a_enqueue_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.operation == sqia_pkg::OP_ENQUEUE && !full)
      |=> count == $past(count) + CW'(1))
    else $error("enqueue did not add one entry");

endmodule

>>> hdl/shift_queue_insert_after.sv
// The result of an item is offered in the cycle after the item is accepted.
// One item per cycle while results are taken; cells compare and shift in parallel.
// A result waiting in the output register blocks a new item only while unaccepted.
// Reset (synchronous, active high) empties the queue and drops any pending result.
// Stored bytes are not cleared; only entries below the count reach a result.
module shift_queue_insert_after #(
  parameter int DEPTH = sqia_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sqia_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sqia_pkg::rsp_item_t rsp
);

  sqia_pkg::dp_cmd_t cmd;

  sqia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  sqia_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

>>> tb/shift_queue_insert_after_test.sv
module shift_queue_insert_after_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = sqia_pkg::DEPTH_DEFAULT;
  localparam int BW = sqia_pkg::BYTE_W;
  localparam int OW = sqia_pkg::OP_W;
  localparam int FW = sqia_pkg::FILL_W;
  localparam int RANDOM_ITEMS = 1150;
  localparam int QUIET_ITEMS = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;

  class byte_queue_scoreboard;
    logic [BW-1:0] mirror_cells[DEPTH];
    int unsigned mirror_count;
    sqia_pkg::rsp_item_t awaited_responses[$];
    int unsigned failures;

    function new();
      mirror_count = 0;
      failures = 0;
    endfunction

    // Applies one operation to the mirrored queue and returns its outcome.
    function sqia_pkg::rsp_item_t next_response(sqia_pkg::req_item_t it);
      sqia_pkg::rsp_item_t outcome;
      int pos;
      outcome.status = sqia_pkg::ST_OK;
      outcome.head_out = '0;
      case (it.operation)
        sqia_pkg::OP_ENQUEUE: begin
          if (mirror_count >= DEPTH) begin
            outcome.status = sqia_pkg::ST_FULL;
          end else begin
            mirror_cells[mirror_count] = it.data_byte;
            mirror_count++;
          end
        end
        sqia_pkg::OP_DEQUEUE: begin
          if (mirror_count == 0) begin
            outcome.status = sqia_pkg::ST_EMPTY;
          end else begin
            outcome.head_out = mirror_cells[0];
            for (int i = 0; i + 1 < mirror_count; i++) mirror_cells[i] = mirror_cells[i + 1];
            mirror_count--;
          end
        end
        sqia_pkg::OP_INSERT: begin
          if (mirror_count >= DEPTH) begin
            outcome.status = sqia_pkg::ST_FULL;
          end else begin
            pos = -1;
            for (int i = 0; i < mirror_count; i++) begin
              if (pos < 0 && mirror_cells[i] == it.target_byte) pos = i;
            end
            if (pos < 0) begin
              outcome.status = sqia_pkg::ST_NOTFOUND;
            end else begin
              for (int i = mirror_count; i > pos + 1; i--) mirror_cells[i] = mirror_cells[i - 1];
              mirror_cells[pos + 1] = it.data_byte;
              mirror_count++;
            end
          end
        end
        default: begin
          mirror_count = 0;
        end
      endcase
      outcome.fill_count = mirror_count[FW-1:0];
      return outcome;
    endfunction

    function void note_request(sqia_pkg::req_item_t it);
      awaited_responses.push_back(next_response(it));
    endfunction

    function void compare_field(string label, logic [BW-1:0] want, logic [BW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        failures++;
      end
    endfunction

    function void check_response(sqia_pkg::rsp_item_t got);
      sqia_pkg::rsp_item_t want;
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual status %0h head %0h fill %0h",
                 $time, got.status, got.head_out, got.fill_count);
        failures++;
        return;
      end
      want = awaited_responses.pop_front();
      compare_field("status", BW'(want.status), BW'(got.status));
      compare_field("head_out", want.head_out, got.head_out);
      compare_field("fill_count", BW'(want.fill_count), BW'(got.fill_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sqia_pkg::req_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sqia_pkg::rsp_item_t rsp;

  bit quiet = 1'b0;
  int unsigned cycle_count = 0;
  byte_queue_scoreboard tracker = new();

  shift_queue_insert_after #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_response(rsp);
  end

  // Result side: ready runs of varied length broken by stalls, always ready near the end.
  initial begin
    forever begin
      if (quiet) begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12)) @(posedge clk);
        if (!quiet) begin
          rsp_ready <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
  end

  function automatic sqia_pkg::req_item_t make_req(logic [OW-1:0] op, logic [BW-1:0] data,
                                                   logic [BW-1:0] target);
    sqia_pkg::req_item_t it;
    it.operation = op;
    it.data_byte = data;
    it.target_byte = target;
    return it;
  endfunction

  // Most insert targets are taken from the queue contents, and half the data bytes
  // come from a narrow range so that duplicates test the first-match rule.
  function automatic sqia_pkg::req_item_t random_request(int unsigned grow_pct);
    sqia_pkg::req_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      it.operation = sqia_pkg::OP_CLEAR;
    end else if (roll < 2 + grow_pct) begin
      it.operation = $urandom_range(0, 1) ? sqia_pkg::OP_ENQUEUE : sqia_pkg::OP_INSERT;
    end else begin
      it.operation = sqia_pkg::OP_DEQUEUE;
    end
    it.data_byte = $urandom_range(0, 1) ? BW'($urandom_range(0, 7))
                                        : BW'($urandom_range(0, 255));
    if (tracker.mirror_count > 0 && $urandom_range(0, 3) != 0) begin
      it.target_byte = tracker.mirror_cells[$urandom_range(0, tracker.mirror_count - 1)];
    end else begin
      it.target_byte = $urandom_range(0, 1) ? BW'($urandom_range(0, 7))
                                            : BW'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic send_request(sqia_pkg::req_item_t it);
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(it);
  endtask

  // Drops valid for a burst and puts junk on the payload while idle.
  task automatic pace_sender(int unsigned gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      req <= make_req(OW'($urandom), BW'($urandom), BW'($urandom));
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned grow_pct;
    int unsigned gap_pct;
    int unsigned settle;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(sqia_pkg::OP_DEQUEUE, 8'h00, 8'h00));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_INSERT, 8'h3C, 8'h3C));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_ENQUEUE, 8'h00, 8'hFF));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_ENQUEUE, 8'hFF, 8'h00));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_INSERT, 8'h55, 8'h00));
    pace_sender(30);
    // Insert behind the last entry lands at the tail.
    send_request(make_req(sqia_pkg::OP_INSERT, 8'hAA, 8'hFF));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_ENQUEUE, 8'h00, 8'h00));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_INSERT, 8'h11, 8'h00));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_INSERT, 8'h22, 8'h77));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_DEQUEUE, 8'hFF, 8'hFF));
    pace_sender(30);
    for (int i = 0; i < 11; i++) begin
      send_request(make_req(sqia_pkg::OP_ENQUEUE,
                            (i < 8) ? (8'h01 << i) : ~(8'h01 << (i - 8)), 8'h00));
      pace_sender(30);
    end
    // The queue is full now: the full check must win over a target that is present.
    send_request(make_req(sqia_pkg::OP_ENQUEUE, 8'h99, 8'h00));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_INSERT, 8'h66, 8'h55));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_DEQUEUE, 8'h00, 8'h00));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_CLEAR, 8'hFF, 8'hFF));
    pace_sender(30);
    send_request(make_req(sqia_pkg::OP_DEQUEUE, 8'h00, 8'h00));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: grow_pct = 85;
        1: grow_pct = 50;
        default: grow_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      burst_len = $urandom_range(20, 60);
      for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
        if (sent == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        send_request(random_request(grow_pct));
        if (!quiet) pace_sender(gap_pct);
        sent++;
      end
    end
    req_valid <= 1'b0;

    while (tracker.awaited_responses.size() != 0) @(posedge clk);
    settle = 4;
    repeat (settle) @(posedge clk);

    if (tracker.failures == 0 && tracker.awaited_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
